### rtl/uafc_pkg.sv
// uafc_pkg: shared types and constants for the udp / arp frame classifier
// frame byte offsets, class codes, register indexes and reset values
// no dependencies
package uafc_pkg;

  typedef logic [5:0]  offset_t;
  typedef logic [2:0]  class_t;
  typedef logic [1:0]  reg_index_t;

  // frame classes
  localparam class_t CLASS_NONE      = 3'd0;
  localparam class_t CLASS_COMMAND   = 3'd1;
  localparam class_t CLASS_DATA      = 3'd2;
  localparam class_t CLASS_ARP_PROBE = 3'd3;
  localparam class_t CLASS_ARP_LOCAL = 3'd4;

  // configuration register indexes
  localparam reg_index_t REG_LOCAL_IP      = 2'd0;
  localparam reg_index_t REG_COMMAND_PORT  = 2'd1;
  localparam reg_index_t REG_DATA_PORT     = 2'd2;
  localparam reg_index_t REG_ARP_ETHERTYPE = 2'd3;

  // register reset values
  localparam logic [31:0] LOCAL_IP_RST      = 32'h6464_64C8;
  localparam logic [15:0] COMMAND_PORT_RST  = 16'hC0DE;
  localparam logic [15:0] DATA_PORT_RST     = 16'hDA7A;
  localparam logic [15:0] ARP_ETHERTYPE_RST = 16'h0806;

  // byte offsets within the frame
  localparam offset_t OFF_MAC_LAST   = 6'd5;
  localparam offset_t OFF_ETYPE_HI   = 6'd12;
  localparam offset_t OFF_ETYPE_LO   = 6'd13;
  localparam offset_t OFF_DST_IP     = 6'd30;
  localparam offset_t OFF_DST_LAST   = 6'd33;
  localparam offset_t OFF_PORT_HI    = 6'd36;
  localparam offset_t OFF_PORT_LO    = 6'd37;
  localparam offset_t OFF_TGT_IP     = 6'd38;
  localparam offset_t OFF_TGT_LAST   = 6'd41;
  localparam offset_t OFF_CMD_FIRST  = 6'd42;
  localparam offset_t OFF_CMD_LAST   = 6'd45;
  localparam offset_t OFF_MAX        = 6'd63;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

  // octet k of an ipv4 address, first octet in the top byte
  function automatic logic [7:0] ip_octet(input logic [31:0] ip, input logic [1:0] k);
    logic [7:0] o;
    begin
      case (k)
        2'd0:    o = ip[31:24];
        2'd1:    o = ip[23:16];
        2'd2:    o = ip[15:8];
        default: o = ip[7:0];
      endcase
      return o;
    end
  endfunction

endpackage

### rtl/udp_arp_frame_classifier_top.sv
// udp_arp_frame_classifier_top: streaming ethernet frame classifier
// depends on uafc_pkg for offsets, class codes and register indexes
// single module, no submodules
//
// Frame bytes enter one transaction per byte, in wire order, with
// in_end_of_frame high on the last byte. Each byte is taken into an input
// register and then folded into a byte offset and a handful of match flags
// (broadcast mac, arp ethertype, destination ip prefix and last octet, udp
// destination port, arp target ip, command word). The byte that ends a frame
// also fills in the missing bytes of a short frame as zeros and loads one
// result transaction into the output register: class 1 command, 2 data (ip
// destination is ours or our /24 broadcast, matched by udp port), 4 arp
// request for us, 3 arp probe, 0 none. out_command_word holds bytes 42..45
// big-endian for command frames and zero otherwise. The block takes one byte per
// clock; a frame's last byte waits in the input register only while an earlier
// result sits unaccepted in the output register, so the rate holds whenever
// out_ready keeps up. A last byte passes the input, then the output register.
// Registers are written through the cfg port, which is always ready; the user
// must write them only while no frame is in flight; the block does not enforce it.
module udp_arp_frame_classifier_top
  import uafc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_end_of_frame,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_class,
  output logic [31:0] out_command_word,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] local_ip_r;
  logic [15:0] command_port_r;
  logic [15:0] data_port_r;
  logic [15:0] arp_ethertype_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r      <= LOCAL_IP_RST;
      command_port_r  <= COMMAND_PORT_RST;
      data_port_r     <= DATA_PORT_RST;
      arp_ethertype_r <= ARP_ETHERTYPE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOCAL_IP:      local_ip_r      <= cfg_data;
        REG_COMMAND_PORT:  command_port_r  <= cfg_data[15:0];
        REG_DATA_PORT:     data_port_r     <= cfg_data[15:0];
        REG_ARP_ETHERTYPE: arp_ethertype_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eof_r;
  logic       advance;
  logic       out_valid_r;

  // a byte moves on unless it ends a frame and the result slot is still full
  assign advance  = in_vld_r && (!in_eof_r || !out_valid_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_frame_byte;
      in_eof_r  <= in_end_of_frame;
    end
  end

  // per-frame state
  offset_t     byte_offset_r;
  logic        mac_ok_r, prefix_ok_r, last_ok_r, etype_ok_r, target_ok_r;
  logic [7:0]  port_hi_r;
  logic [15:0] port_value_r;
  logic [31:0] cmd_shift_r;

  // state after this byte
  offset_t     off;
  logic        abs_mac, abs_prefix, abs_last, abs_etype, abs_target;
  logic [7:0]  abs_port_hi;
  logic [15:0] abs_port;
  logic [31:0] abs_cmd;

  assign off = byte_offset_r;

  always_comb begin
    abs_mac     = mac_ok_r;
    abs_prefix  = prefix_ok_r;
    abs_last    = last_ok_r;
    abs_etype   = etype_ok_r;
    abs_target  = target_ok_r;
    abs_port_hi = port_hi_r;
    abs_port    = port_value_r;
    abs_cmd     = cmd_shift_r;
    if (off <= OFF_MAC_LAST) begin
      if (in_byte_r != BYTE_ALL_ONES) abs_mac = 1'b0;
    end else if (off == OFF_ETYPE_HI) begin
      if (in_byte_r != arp_ethertype_r[15:8]) abs_etype = 1'b0;
    end else if (off == OFF_ETYPE_LO) begin
      if (in_byte_r != arp_ethertype_r[7:0]) abs_etype = 1'b0;
    end else if (off inside {[OFF_DST_IP:OFF_DST_LAST - 6'd1]}) begin
      if (in_byte_r != ip_octet(local_ip_r, 2'(off - OFF_DST_IP))) abs_prefix = 1'b0;
    end else if (off == OFF_DST_LAST) begin
      abs_last = (in_byte_r == local_ip_r[7:0]) || (in_byte_r == BYTE_ALL_ONES);
    end else if (off == OFF_PORT_HI) begin
      abs_port_hi = in_byte_r;
    end else if (off == OFF_PORT_LO) begin
      abs_port = {port_hi_r, in_byte_r};
    end else if (off inside {[OFF_TGT_IP:OFF_TGT_LAST]}) begin
      if (in_byte_r != ip_octet(local_ip_r, 2'(off - OFF_TGT_IP))) abs_target = 1'b0;
    end else if (off inside {[OFF_CMD_FIRST:OFF_CMD_LAST]}) begin
      abs_cmd = {cmd_shift_r[23:0], in_byte_r};
    end
  end

  // short frame: every byte past the current offset up to the command word is zero
  logic        fin_mac, fin_prefix, fin_last, fin_etype, fin_target;
  logic [7:0]  fin_port_hi;
  logic [15:0] fin_port;
  logic [31:0] fin_cmd;

  always_comb begin
    fin_mac   = abs_mac && !(off < OFF_MAC_LAST);
    fin_etype = abs_etype
                && !(off < OFF_ETYPE_HI && arp_ethertype_r[15:8] != 8'h00)
                && !(off < OFF_ETYPE_LO && arp_ethertype_r[7:0] != 8'h00);
    fin_prefix = abs_prefix
                 && !(off < OFF_DST_IP          && local_ip_r[31:24] != 8'h00)
                 && !(off < OFF_DST_IP + 6'd1   && local_ip_r[23:16] != 8'h00)
                 && !(off < OFF_DST_IP + 6'd2   && local_ip_r[15:8]  != 8'h00);
    fin_last    = (off < OFF_DST_LAST) ? (local_ip_r[7:0] == 8'h00) : abs_last;
    fin_port_hi = (off < OFF_PORT_HI) ? 8'h00 : abs_port_hi;
    fin_port    = (off < OFF_PORT_LO) ? {fin_port_hi, 8'h00} : abs_port;
    fin_target = abs_target
                 && !(off < OFF_TGT_IP          && local_ip_r[31:24] != 8'h00)
                 && !(off < OFF_TGT_IP + 6'd1   && local_ip_r[23:16] != 8'h00)
                 && !(off < OFF_TGT_IP + 6'd2   && local_ip_r[15:8]  != 8'h00)
                 && !(off < OFF_TGT_LAST        && local_ip_r[7:0]   != 8'h00);
    if (off < OFF_CMD_FIRST) begin
      fin_cmd = 32'h0;
    end else if (off == OFF_CMD_FIRST) begin
      fin_cmd = {abs_cmd[7:0], 24'h0};
    end else if (off == OFF_CMD_FIRST + 6'd1) begin
      fin_cmd = {abs_cmd[15:0], 16'h0};
    end else if (off == OFF_CMD_FIRST + 6'd2) begin
      fin_cmd = {abs_cmd[23:0], 8'h0};
    end else begin
      fin_cmd = abs_cmd;
    end
  end

  // classification, first matching rule wins
  class_t      cls_nxt;
  logic [31:0] word_nxt;

  always_comb begin
    cls_nxt  = CLASS_NONE;
    word_nxt = 32'h0;
    if (fin_prefix && fin_last) begin
      if (fin_port == command_port_r) begin
        cls_nxt  = CLASS_COMMAND;
        word_nxt = fin_cmd;
      end else if (fin_port == data_port_r) begin
        cls_nxt = CLASS_DATA;
      end
    end else if (fin_mac && fin_etype) begin
      cls_nxt = fin_target ? CLASS_ARP_LOCAL : CLASS_ARP_PROBE;
    end
  end

  // frame state update, cleared at frame end
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_eof_r)) begin
      byte_offset_r <= '0;
      mac_ok_r      <= 1'b1;
      prefix_ok_r   <= 1'b1;
      last_ok_r     <= 1'b0;
      etype_ok_r    <= 1'b1;
      target_ok_r   <= 1'b1;
      port_hi_r     <= 8'h00;
      port_value_r  <= 16'h0;
      cmd_shift_r   <= 32'h0;
    end else if (advance) begin
      if (byte_offset_r != OFF_MAX) byte_offset_r <= byte_offset_r + 6'd1;
      mac_ok_r     <= abs_mac;
      prefix_ok_r  <= abs_prefix;
      last_ok_r    <= abs_last;
      etype_ok_r   <= abs_etype;
      target_ok_r  <= abs_target;
      port_hi_r    <= abs_port_hi;
      port_value_r <= abs_port;
      cmd_shift_r  <= abs_cmd;
    end
  end

  // result register
  class_t      out_class_r;
  logic [31:0] out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_eof_r) begin
      out_class_r <= cls_nxt;
      out_word_r  <= word_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_class  = out_class_r;
  assign out_command_word = out_word_r;

  // frame state returns to its start after a frame ends
  a_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_eof_r |=> byte_offset_r == '0 && mac_ok_r && !last_ok_r)
    else $error("frame state not cleared after end of frame");

  // a byte that cannot move on stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r) && $stable(in_eof_r))
    else $error("stalled byte lost from input register");

  // an unaccepted result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(advance && in_eof_r))
    else $error("pending result overwritten");

  // command word only for command frames
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_class_r != CLASS_COMMAND |-> out_word_r == 32'h0)
    else $error("command word set on non-command frame");

endmodule

### tb/sv/udp_arp_frame_classifier_top_tb.sv
`timescale 1ns / 100ps
// udp_arp_frame_classifier_top_tb: self-checking bench for the frame classifier
// streams ethernet frames byte by byte, predicts each frame class, checks results
// depends on uafc_pkg and udp_arp_frame_classifier_top
module udp_arp_frame_classifier_top_tb;
  import uafc_pkg::*;

  localparam int unsigned FRAME_BUF    = 128;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // one byte transaction of the input stream
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } frame_beat_t;

  // one expected result transaction
  typedef struct packed {
    class_t      cls;
    logic [31:0] word;
  } frame_result_t;

  // shapes of generated frames
  typedef enum {FRM_IP_LOCAL, FRM_IP_BCAST, FRM_ARP_LOCAL, FRM_ARP_OTHER, FRM_NOISE}
    frame_kind_t;
  typedef enum {PICK_CMD, PICK_DATA, PICK_ANY} port_pick_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte    = 8'h00;
  logic        in_end_of_frame  = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [2:0]  out_frame_class;
  logic [31:0] out_command_word;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index        = REG_LOCAL_IP;
  logic [31:0] cfg_data         = 32'h0;

  udp_arp_frame_classifier_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_byte    (in_frame_byte),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_class  (out_frame_class),
    .out_command_word (out_command_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // bytes waiting to be offered, and frame results still owed by the block
  frame_beat_t   tx_bytes[$];
  frame_result_t pending_results[$];

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off, started by a one-cycle pulse
  logic        hold_start = 1'b0;
  int unsigned hold_left  = 0;

  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;

  // bench copy of the configuration registers
  logic [31:0] cur_local_ip = LOCAL_IP_RST;
  logic [15:0] cur_cmd_port = COMMAND_PORT_RST;
  logic [15:0] cur_data_port = DATA_PORT_RST;
  logic [15:0] cur_etype    = ARP_ETHERTYPE_RST;

  // bench copy of the per-frame match state
  int unsigned frm_offset    = 0;
  logic        bcast_ok      = 1'b1;
  logic        dst_prefix_ok = 1'b1;
  logic        dst_last_ok   = 1'b0;
  logic        etype_ok      = 1'b1;
  logic [7:0]  port_hi       = 8'h00;
  logic [15:0] port_val      = 16'h0000;
  logic        tgt_ok        = 1'b1;
  logic [31:0] cmd_word      = 32'h0;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // classification predictor
  // ---------------------------------------------------------------------------

  // octet k of the local address, first octet on the wire first
  function automatic logic [7:0] local_octet(int unsigned k);
    return cur_local_ip[31 - 8*k -: 8];
  endfunction

  // fold one byte at a given frame offset into the match flags
  function automatic void fold_byte(int unsigned off, logic [7:0] b);
    if (off <= OFF_MAC_LAST) begin
      if (b != BYTE_ALL_ONES) bcast_ok = 1'b0;
    end else if (off == OFF_ETYPE_HI) begin
      if (b != cur_etype[15:8]) etype_ok = 1'b0;
    end else if (off == OFF_ETYPE_LO) begin
      if (b != cur_etype[7:0]) etype_ok = 1'b0;
    end else if (off >= OFF_DST_IP && off < OFF_DST_LAST) begin
      if (b != local_octet(off - OFF_DST_IP)) dst_prefix_ok = 1'b0;
    end else if (off == OFF_DST_LAST) begin
      // our own address or the /24 broadcast
      dst_last_ok = (b == cur_local_ip[7:0]) || (b == BYTE_ALL_ONES);
    end else if (off == OFF_PORT_HI) begin
      port_hi = b;
    end else if (off == OFF_PORT_LO) begin
      port_val = {port_hi, b};
    end else if (off >= OFF_TGT_IP && off <= OFF_TGT_LAST) begin
      if (b != local_octet(off - OFF_TGT_IP)) tgt_ok = 1'b0;
    end else if (off >= OFF_CMD_FIRST && off <= OFF_CMD_LAST) begin
      cmd_word = {cmd_word[23:0], b};
    end
  endfunction

  function automatic void clear_frame_state();
    frm_offset    = 0;
    bcast_ok      = 1'b1;
    dst_prefix_ok = 1'b1;
    dst_last_ok   = 1'b0;
    etype_ok      = 1'b1;
    port_hi       = 8'h00;
    port_val      = 16'h0000;
    tgt_ok        = 1'b1;
    cmd_word      = 32'h0;
  endfunction

  // advance the predictor by one accepted byte; a last byte yields a result
  function automatic void classify_byte(logic [7:0] b, logic last);
    frame_result_t r;
    int unsigned   off;
    off = frm_offset;
    fold_byte(off, b);
    if (frm_offset < OFF_MAX) frm_offset++;
    if (last) begin
      // bytes a short frame never carried count as zero
      for (int unsigned k = off + 1; k <= OFF_CMD_LAST; k++) fold_byte(k, 8'h00);
      r.cls  = CLASS_NONE;
      r.word = 32'h0;
      if (dst_prefix_ok && dst_last_ok) begin
        // command port wins when both ports are equal
        if (port_val == cur_cmd_port) begin
          r.cls  = CLASS_COMMAND;
          r.word = cmd_word;
        end else if (port_val == cur_data_port) begin
          r.cls = CLASS_DATA;
        end
      end else if (bcast_ok && etype_ok) begin
        r.cls = tgt_ok ? CLASS_ARP_LOCAL : CLASS_ARP_PROBE;
      end
      pending_results.push_back(r);
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // frame generation
  // ---------------------------------------------------------------------------

  // build one frame of the given shape against the current registers and queue
  // its bytes; corrupt flips one bit somewhere in the classified header bytes
  function automatic void queue_frame(frame_kind_t kind, port_pick_t pick,
                                      int unsigned len, bit corrupt);
    logic [7:0]  fb [0:FRAME_BUF-1];
    logic [31:0] rnd;
    logic [15:0] port;
    logic [31:0] tgt;
    bit          arp_hdr;
    int unsigned k;
    frame_beat_t beat;
    for (k = 0; k < FRAME_BUF; k++) begin
      rnd   = $urandom;
      fb[k] = rnd[7:0];
    end
    rnd = $urandom;
    case (pick)
      PICK_CMD:  port = cur_cmd_port;
      PICK_DATA: port = cur_data_port;
      default:   port = rnd[15:0];
    endcase
    if (kind == FRM_IP_LOCAL || kind == FRM_IP_BCAST) begin
      for (k = 0; k < 4; k++) fb[OFF_DST_IP + k] = local_octet(k);
      if (kind == FRM_IP_BCAST) fb[OFF_DST_LAST] = BYTE_ALL_ONES;
      fb[OFF_PORT_HI] = port[15:8];
      fb[OFF_PORT_LO] = port[7:0];
    end
    // now and then a non-arp frame also carries an arp broadcast header
    arp_hdr = (kind == FRM_ARP_LOCAL || kind == FRM_ARP_OTHER) || ($urandom_range(9) == 0);
    if (arp_hdr) begin
      for (k = 0; k <= OFF_MAC_LAST; k++) fb[k] = BYTE_ALL_ONES;
      fb[OFF_ETYPE_HI] = cur_etype[15:8];
      fb[OFF_ETYPE_LO] = cur_etype[7:0];
      tgt = cur_local_ip;
      if (kind == FRM_ARP_OTHER) tgt = cur_local_ip ^ (32'd1 << $urandom_range(31));
      for (k = 0; k < 4; k++) fb[OFF_TGT_IP + k] = tgt[31 - 8*k -: 8];
    end
    if (corrupt) begin
      k     = $urandom_range(OFF_CMD_LAST);
      fb[k] = fb[k] ^ (8'h01 << $urandom_range(7));
    end
    for (k = 0; k < len; k++) begin
      beat.data = fb[k];
      beat.eof  = (k == len - 1);
      tx_bytes.push_back(beat);
    end
  endfunction

  // random shape, port choice and length; returns the number of bytes queued
  function automatic int unsigned queue_random_frame(bit short_only);
    frame_kind_t kind;
    port_pick_t  pick;
    int unsigned p;
    int unsigned len;
    p = $urandom_range(99);
    if (p < 40)      kind = FRM_IP_LOCAL;
    else if (p < 55) kind = FRM_IP_BCAST;
    else if (p < 70) kind = FRM_ARP_LOCAL;
    else if (p < 85) kind = FRM_ARP_OTHER;
    else             kind = FRM_NOISE;
    p = $urandom_range(99);
    if (p < 40)      pick = PICK_CMD;
    else if (p < 75) pick = PICK_DATA;
    else             pick = PICK_ANY;
    p = $urandom_range(99);
    if (short_only)  len = $urandom_range(12, 1);
    else if (p < 55) len = $urandom_range(64, 46);
    else if (p < 85) len = $urandom_range(45, 1);
    else             len = $urandom_range(100, 65);
    queue_frame(kind, pick, len, $urandom_range(4) == 0);
    return len;
  endfunction

  task automatic fill_random(int unsigned min_bytes, int unsigned min_frames, bit short_only);
    int unsigned nbytes;
    int unsigned nframes;
    nbytes  = 0;
    nframes = 0;
    while (nbytes < min_bytes || nframes < min_frames) begin
      nbytes += queue_random_frame(short_only);
      nframes++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------

  task automatic flag_error(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // one register write transaction; the bench copy follows on acceptance
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOCAL_IP:      cur_local_ip  = val;
      REG_COMMAND_PORT:  cur_cmd_port  = val[15:0];
      REG_DATA_PORT:     cur_data_port = val[15:0];
      REG_ARP_ETHERTYPE: cur_etype     = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] ip, logic [31:0] cmd_port,
                             logic [31:0] data_port, logic [31:0] etype);
    write_reg(REG_LOCAL_IP, ip);
    write_reg(REG_COMMAND_PORT, cmd_port);
    write_reg(REG_DATA_PORT, data_port);
    write_reg(REG_ARP_ETHERTYPE, etype);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // wait until every byte went in and every result came out, then let the
  // pipeline settle so a trailing non-final byte is fully absorbed
  task automatic wait_drained();
    do @(posedge clk);
    while (tx_bytes.size() != 0 || in_valid || pending_results.size() != 0 ||
           hold_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: offers queued bytes, feeds accepted ones to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    frame_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) classify_byte(in_frame_byte, in_end_of_frame);
      // the slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = tx_bytes.pop_front();
          in_valid        <= 1'b1;
          in_frame_byte   <= beat.data;
          in_end_of_frame <= beat.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long hold-off counter for the back-pressure phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hold_counter
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares every result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result, class %0d word %h",
                               out_frame_class, out_command_word));
        end else begin
          want = pending_results.pop_front();
          if (out_frame_class !== want.cls)
            flag_error($sformatf("frame class %0d, expected %0d",
                                 out_frame_class, want.cls));
          if (out_command_word !== want.word)
            flag_error($sformatf("command word %h, expected %h",
                                 out_command_word, want.word));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, no idling; directed frames first
    set_idling(0, 0);
    queue_frame(FRM_IP_LOCAL, PICK_CMD, 46, 1'b0);   // command, full header
    queue_frame(FRM_IP_BCAST, PICK_DATA, 46, 1'b0);  // data to the /24 broadcast
    queue_frame(FRM_IP_LOCAL, PICK_ANY, 40, 1'b0);   // unknown port, no command bytes
    queue_frame(FRM_IP_LOCAL, PICK_CMD, 44, 1'b0);   // command word cut short
    queue_frame(FRM_ARP_LOCAL, PICK_ANY, 42, 1'b0);  // arp request for us
    queue_frame(FRM_ARP_OTHER, PICK_ANY, 46, 1'b0);  // arp probe
    queue_frame(FRM_IP_LOCAL, PICK_CMD, 66, 1'b0);   // long frame, offset saturates
    queue_frame(FRM_NOISE, PICK_ANY, 1, 1'b0);       // one-byte frame
    wait_drained();

    // all registers zero: short frames match the address and both ports
    load_config(32'h0, 32'h0, 32'h0, 32'h0);
    set_idling(45, 0);
    queue_frame(FRM_NOISE, PICK_ANY, 1, 1'b0);
    queue_frame(FRM_IP_LOCAL, PICK_CMD, 43, 1'b0);
    fill_random(0, 1, 1'b0);
    wait_drained();

    // all registers ones: ports equal again, address all ones
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_idling(0, 45);
    queue_frame(FRM_IP_LOCAL, PICK_CMD, 46, 1'b0);
    queue_frame(FRM_ARP_LOCAL, PICK_ANY, 46, 1'b0);
    fill_random(0, 1, 1'b0);
    wait_drained();

    // random registers, both sides idling
    load_config($urandom, $urandom, $urandom, $urandom);
    set_idling(33, 33);
    fill_random(40, 1, 1'b0);
    wait_drained();

    // back-pressure: receiver holds off while short frames keep arriving
    load_config($urandom, $urandom, $urandom, $urandom);
    set_idling(0, 0);
    fill_random(30, 8, 1'b1);
    fill_random(0, 1, 1'b0);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();

    // reset values again, full rate
    load_config(LOCAL_IP_RST, COMMAND_PORT_RST, DATA_PORT_RST, ARP_ETHERTYPE_RST);
    set_idling(0, 0);
    fill_random(0, 1, 1'b0);
    wait_drained();

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
